/* rtl/core/tes3_mlp_pkg.sv */
// Shared types and constants for the plugin master list parser.
// Used by tes3_mlp_parser, tes3_mlp_queue and tes3_master_list_parser.
`default_nettype none

package tes3_mlp_pkg;

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_END    = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_byte;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  count;
        t_result     first;
        t_result     second;
    } t_push;

    localparam logic [7:0] FILE_TAG [4]   = '{8'h54, 8'h45, 8'h53, 8'h33};
    localparam logic [7:0] MASTER_TAG [4] = '{8'h4D, 8'h41, 8'h53, 8'h54};

    localparam int unsigned HEADER_LEN = 16;
    localparam int unsigned SUBHDR_LEN = 8;
    localparam int unsigned TAG_LEN    = 4;

    localparam logic [3:0] HEADER_LAST = 4'(HEADER_LEN - 1);
    localparam logic [2:0] SUBHDR_LAST = 3'(SUBHDR_LEN - 1);
    localparam logic [7:0] NUL_BYTE    = 8'h00;

endpackage

`default_nettype wire

/* rtl/core/tes3_mlp_parser.sv */
// Parser state and per-beat decode: header check, subrecord walk, name extraction.
// Depends on tes3_mlp_pkg; feeds up to two results per beat to tes3_mlp_queue.
`default_nettype none

module tes3_mlp_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_end_of_file,
    output tes3_mlp_pkg::t_push       o_push
);
    import tes3_mlp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SUBHDR,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DONE,
        PH_BADTAG
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [3:0]  r_header_idx,  n_header_idx;
    logic        r_header_good, n_header_good;
    logic [31:0] r_body_left,   n_body_left;
    logic [2:0]  r_sub_idx,     n_sub_idx;
    logic        r_is_master,   n_is_master;
    logic [31:0] r_sub_size,    n_sub_size;
    logic [31:0] r_pay_left,    n_pay_left;
    logic        r_null_seen,   n_null_seen;

    logic [31:0] left_dec;
    logic [31:0] pay_dec;
    logic [31:0] sub_full;
    logic        start_sub;
    logic        emit_name;
    logic        emit_end;
    logic        in_body;
    t_result     res_name;
    t_result     res_end;
    t_result     res_verdict;

    always_comb begin
        n_phase       = r_phase;
        n_header_idx  = r_header_idx;
        n_header_good = r_header_good;
        n_body_left   = r_body_left;
        n_sub_idx     = r_sub_idx;
        n_is_master   = r_is_master;
        n_sub_size    = r_sub_size;
        n_pay_left    = r_pay_left;
        n_null_seen   = r_null_seen;

        left_dec  = r_body_left - 32'd1;
        pay_dec   = r_pay_left - 32'd1;
        sub_full  = {i_data_byte, r_sub_size[23:0]};
        start_sub = 1'b0;
        emit_name = 1'b0;
        emit_end  = 1'b0;
        in_body   = (r_phase == PH_SUBHDR) || (r_phase == PH_PAYLOAD) ||
                    (r_phase == PH_SKIP);

        res_name    = '{kind: KIND_NAME, name_byte: i_data_byte, last: 1'b0};
        res_end     = '{kind: KIND_END, name_byte: 8'd0, last: 1'b1};
        res_verdict = '{kind: (r_phase == PH_DONE && r_header_good) ? KIND_ACCEPT
                                                                    : KIND_REJECT,
                        name_byte: 8'd0, last: 1'b1};
        o_push = '0;

        if (i_accept && i_end_of_file) begin
            o_push.count  = 2'd1;
            o_push.first  = res_verdict;
            n_phase       = PH_HEADER;
            n_header_idx  = '0;
            n_header_good = 1'b1;
            n_body_left   = '0;
            n_sub_idx     = '0;
            n_is_master   = 1'b1;
            n_sub_size    = '0;
            n_pay_left    = '0;
            n_null_seen   = 1'b0;
        end else if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_header_idx = r_header_idx + 4'd1;
                    if (r_header_idx < 4'(TAG_LEN)) begin
                        if (i_data_byte != FILE_TAG[r_header_idx[1:0]]) begin
                            n_header_good = 1'b0;
                        end
                    end else if (r_header_idx < 4'(2 * TAG_LEN)) begin
                        n_body_left[8 * r_header_idx[1:0] +: 8] = i_data_byte;
                    end
                    if (r_header_idx == HEADER_LAST) begin
                        if (!r_header_good) begin
                            n_phase = PH_BADTAG;
                        end else if (r_body_left == 32'd0) begin
                            n_phase = PH_DONE;
                        end else if (r_body_left < 32'(SUBHDR_LEN)) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_SUBHDR;
                        end
                    end
                end
                PH_SUBHDR: begin
                    n_body_left = left_dec;
                    n_sub_idx   = r_sub_idx + 3'd1;
                    if (r_sub_idx < 3'(TAG_LEN)) begin
                        if (i_data_byte != MASTER_TAG[r_sub_idx[1:0]]) begin
                            n_is_master = 1'b0;
                        end
                    end else begin
                        n_sub_size[8 * r_sub_idx[1:0] +: 8] = i_data_byte;
                    end
                    if (r_sub_idx == SUBHDR_LAST) begin
                        if (sub_full >= r_body_left) begin
                            n_phase = PH_SKIP;
                        end else if (sub_full == 32'd0) begin
                            emit_end  = r_is_master;
                            start_sub = 1'b1;
                        end else begin
                            n_pay_left  = sub_full;
                            n_null_seen = 1'b0;
                            n_phase     = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_body_left = left_dec;
                    n_pay_left  = pay_dec;
                    if (r_is_master && !r_null_seen) begin
                        if (i_data_byte == NUL_BYTE) begin
                            n_null_seen = 1'b1;
                        end else begin
                            emit_name = 1'b1;
                        end
                    end
                    if (pay_dec == 32'd0) begin
                        emit_end  = r_is_master;
                        start_sub = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_body_left = left_dec;
                end
                default: begin
                end
            endcase

            if (start_sub) begin
                n_sub_idx   = '0;
                n_is_master = 1'b1;
                n_sub_size  = '0;
                n_pay_left  = '0;
                n_null_seen = 1'b0;
                n_phase     = (left_dec < 32'(SUBHDR_LEN)) ? PH_SKIP : PH_SUBHDR;
            end
            if (in_body && left_dec == 32'd0) begin
                n_phase = PH_DONE;
            end

            if (emit_name && emit_end) begin
                o_push.count  = 2'd2;
                o_push.first  = res_name;
                o_push.second = res_end;
            end else if (emit_name) begin
                o_push.count      = 2'd1;
                o_push.first      = res_name;
                o_push.first.last = 1'b1;
            end else if (emit_end) begin
                o_push.count = 2'd1;
                o_push.first = res_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_header_idx  <= '0;
            r_header_good <= 1'b1;
            r_body_left   <= '0;
            r_sub_idx     <= '0;
            r_is_master   <= 1'b1;
            r_sub_size    <= '0;
            r_pay_left    <= '0;
            r_null_seen   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_header_idx  <= n_header_idx;
            r_header_good <= n_header_good;
            r_body_left   <= n_body_left;
            r_sub_idx     <= n_sub_idx;
            r_is_master   <= n_is_master;
            r_sub_size    <= n_sub_size;
            r_pay_left    <= n_pay_left;
            r_null_seen   <= n_null_seen;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tes3_mlp_queue.sv */
// Three-entry result queue: takes up to two results per beat, hands out one.
// Depends on tes3_mlp_pkg.
`default_nettype none

module tes3_mlp_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tes3_mlp_pkg::t_push  i_push,
    input  wire logic                 i_pop,
    output tes3_mlp_pkg::t_result     o_head,
    output logic                      o_valid,
    output logic                      o_full
);
    import tes3_mlp_pkg::*;

    t_result    r_slot [3];
    t_result    n_slot [3];
    logic [1:0] r_count, n_count;
    logic [1:0] count_pop;

    always_comb begin
        count_pop = r_count - {1'b0, i_pop};
        for (int j = 0; j < 3; j++) begin
            n_slot[j] = r_slot[j];
        end
        if (i_pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
        end
        if (i_push.count != 2'd0) begin
            n_slot[count_pop] = i_push.first;
        end
        if (i_push.count == 2'd2 && count_pop != 2'd2) begin
            n_slot[count_pop + 2'd1] = i_push.second;
        end
        n_count = count_pop + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_slot[j] <= n_slot[j];
        end
    end

    assign o_head  = r_slot[0];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = r_count[1];

endmodule

`default_nettype wire

/* rtl/core/tes3_master_list_parser.sv */
// Top level of the plugin master list parser.
// Depends on tes3_mlp_pkg, tes3_mlp_parser and tes3_mlp_queue.
`default_nettype none

// Takes one file byte per input beat and decodes it in the same cycle, so a
// steady stream runs at one byte per clock while o_stall is low. Results leave
// through a three-entry queue at one beat per clock while i_stall is low; a
// payload byte that ends a master name yields two results (name byte, end of
// name). i_stall on the output is seen by the input only through the queue:
// o_stall rises once two or more results wait, in the cycle after the fact.
// The end-of-file beat yields the verdict and returns the parser to its reset
// state, ready for the next file on the following beat. No clearing pass.
module tes3_master_list_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_end_of_file,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_name_byte,
    output logic                      o_last
);
    import tes3_mlp_pkg::*;

    logic    accept;
    logic    pop;
    logic    full;
    t_push   push;
    t_result head;

    assign accept  = i_valid && !full;
    assign pop     = o_valid && !i_stall;
    assign o_stall = full;

    tes3_mlp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (push)
    );

    tes3_mlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (o_valid),
        .o_full  (full)
    );

    assign o_kind      = head.kind;
    assign o_name_byte = head.name_byte;
    assign o_last      = head.last;

endmodule

`default_nettype wire

/* bench/tes3_master_list_parser_test.sv */
// Self-checking bench for tes3_master_list_parser: feeds plugin files byte by byte,
// predicts every name, end-of-name and verdict beat, and checks the output stream in order.
// Depends on tes3_mlp_pkg and the parser RTL; reads no files.
module tes3_master_list_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tes3_mlp_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 5;
    localparam int FILE_BEATS   = 880;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int GAP_MAX      = 6;
    localparam int BURST_MAX    = 12;
    localparam int STALL_MAX    = 8;

    typedef enum logic [2:0] {
        PS_HEADER, PS_SUBHDR, PS_PAYLOAD, PS_SKIP, PS_DONE, PS_BADTAG
    } t_parse_state;

    typedef enum int { STALL_NONE, STALL_COIN, STALL_RUNS } t_stall_mode;

    typedef logic [7:0] t_byte_q [$];

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_file = 1'b0;
    logic       i_stall = 1'b0;
    wire        o_stall;
    wire        o_valid;
    wire  [1:0] o_kind;
    wire  [7:0] o_name_byte;
    wire        o_last;

    tes3_master_list_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_name_byte   (o_name_byte),
        .o_last        (o_last)
    );

    // parser state mirrored by the predictor
    t_parse_state ps;
    logic [3:0]   hdr_pos;
    logic         hdr_ok;
    logic [31:0]  body_len;
    logic [31:0]  body_count;
    logic [2:0]   sub_pos;
    logic         sub_is_mast;
    logic [31:0]  sub_len;
    logic [31:0]  payload_rem;
    logic         name_done;

    t_result     pending_results [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          file_beats = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    always begin
        #(CLK_LOW) i_clk = 1'b1;
        #(CLK_HIGH) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tes3_master_list_parser_test NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
            case (stall_mode)
                STALL_COIN: i_stall = 1'($urandom_range(0, 1));
                STALL_RUNS: if ($urandom_range(0, 5) == 0) begin
                    i_stall = 1'b1;
                    stall_left = $urandom_range(0, STALL_MAX - 1);
                end
                default: i_stall = 1'b0;
            endcase
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d byte %02h last %0b",
                                          o_kind, o_name_byte, o_last));
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_name_byte !== want.name_byte
                        || o_last !== want.last)
                    report_mismatch($sformatf(
                        "expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                        want.kind, want.name_byte, want.last, o_kind, o_name_byte, o_last));
            end
        end
    end

    function automatic t_result make_result(input t_kind k, input logic [7:0] nb);
        t_result r;
        r.kind      = k;
        r.name_byte = (k == KIND_NAME) ? nb : 8'h00;
        r.last      = 1'b0;
        return r;
    endfunction

    task automatic clear_parser_state();
        ps          = PS_HEADER;
        hdr_pos     = '0;
        hdr_ok      = 1'b1;
        body_len    = '0;
        body_count  = '0;
        sub_pos     = '0;
        sub_is_mast = 1'b1;
        sub_len     = '0;
        payload_rem = '0;
        name_done   = 1'b0;
    endtask

    task automatic open_subrecord();
        sub_pos     = '0;
        sub_is_mast = 1'b1;
        sub_len     = '0;
        payload_rem = '0;
        name_done   = 1'b0;
        if ({1'b0, body_count} + 33'd8 > {1'b0, body_len}) ps = PS_SKIP;
        else ps = PS_SUBHDR;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic eof);
        t_result    produced [2];
        int         n;
        logic [3:0] hp;
        logic [2:0] sp;
        n = 0;
        if (eof) begin
            produced[0] = make_result((hdr_ok && ps == PS_DONE) ? KIND_ACCEPT : KIND_REJECT,
                                      8'h00);
            n = 1;
            clear_parser_state();
        end else if (ps == PS_HEADER) begin
            hp = hdr_pos;
            if (hp < 4) begin
                if (b != FILE_TAG[hp]) hdr_ok = 1'b0;
            end else if (hp < 8) begin
                body_len[8 * (int'(hp) - 4) +: 8] = b;
            end
            hdr_pos = hp + 4'd1;
            if (hp == HEADER_LAST) begin
                body_count = '0;
                if (!hdr_ok) begin
                    ps = PS_BADTAG;
                end else begin
                    open_subrecord();
                    if (body_count == body_len) ps = PS_DONE;
                end
            end
        end else if (ps == PS_SUBHDR || ps == PS_PAYLOAD || ps == PS_SKIP) begin
            body_count++;
            if (ps == PS_SUBHDR) begin
                sp = sub_pos;
                if (sp < 4) begin
                    if (b != MASTER_TAG[sp]) sub_is_mast = 1'b0;
                end else begin
                    sub_len[8 * (int'(sp) - 4) +: 8] = b;
                end
                sub_pos = sp + 3'd1;
                if (sp == SUBHDR_LAST) begin
                    if ({1'b0, body_count} + {1'b0, sub_len} > {1'b0, body_len}) begin
                        ps = PS_SKIP;
                    end else if (sub_len == 0) begin
                        if (sub_is_mast) begin
                            produced[n] = make_result(KIND_END, 8'h00);
                            n++;
                        end
                        open_subrecord();
                    end else begin
                        payload_rem = sub_len;
                        name_done   = 1'b0;
                        ps          = PS_PAYLOAD;
                    end
                end
            end else if (ps == PS_PAYLOAD) begin
                if (sub_is_mast && !name_done) begin
                    if (b == NUL_BYTE) begin
                        name_done = 1'b1;
                    end else begin
                        produced[n] = make_result(KIND_NAME, b);
                        n++;
                    end
                end
                payload_rem--;
                if (payload_rem == 0) begin
                    if (sub_is_mast) begin
                        produced[n] = make_result(KIND_END, 8'h00);
                        n++;
                    end
                    open_subrecord();
                end
            end
            if (body_count == body_len) ps = PS_DONE;
        end
        if (n > 0) produced[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(produced[i]);
    endtask

    task automatic send_beat(input logic [7:0] b, input logic eof);
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge i_clk);
            burst_left = $urandom_range(1, BURST_MAX);
        end
        if (burst_left > 0) burst_left--;
        i_valid       = 1'b1;
        i_data_byte   = b;
        i_end_of_file = eof;
        do @(posedge i_clk); while (o_stall);
        predict_beat(b, eof);
    endtask

    task automatic send_file(input t_byte_q bytes);
        foreach (bytes[i]) send_beat(bytes[i], 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    task automatic add_le32(ref t_byte_q q, input logic [31:0] v);
        for (int i = 0; i < 4; i++) q.push_back(v[8 * i +: 8]);
    endtask

    task automatic add_header(ref t_byte_q q, input logic [31:0] size, input bit tag_ok);
        int base;
        base = q.size();
        for (int i = 0; i < TAG_LEN; i++) q.push_back(FILE_TAG[i]);
        if (!tag_ok) q[base + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        add_le32(q, size);
        repeat (8) q.push_back(8'($urandom));
    endtask

    task automatic add_subhdr(ref t_byte_q q, input bit is_master, input logic [31:0] size);
        int base;
        base = q.size();
        for (int i = 0; i < TAG_LEN; i++) q.push_back(MASTER_TAG[i]);
        if (!is_master) q[base + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        add_le32(q, size);
    endtask

    task automatic choose_idling();
        gaps_on    = ($urandom_range(0, 2) != 0);
        burst_left = 0;
        stall_mode = t_stall_mode'($urandom_range(0, 2));
    endtask

    task automatic test_short_header();
        t_byte_q q;
        send_file(q);
        q = '{8'h54, 8'h45, 8'h53, 8'h33, 8'h10};
        send_file(q);
    endtask

    task automatic test_bad_tag();
        t_byte_q q;
        add_header(q, 32'd8, 1'b0);
        add_subhdr(q, 1'b1, 32'd0);
        send_file(q);
    endtask

    task automatic test_master_names();
        t_byte_q q;
        add_header(q, 32'd48, 1'b1);
        add_subhdr(q, 1'b1, 32'd0);
        add_subhdr(q, 1'b1, 32'd3);
        q.push_back(8'h01);
        q.push_back(NUL_BYTE);
        q.push_back(8'h42);
        add_subhdr(q, 1'b1, 32'd2);
        q.push_back(NUL_BYTE);
        q.push_back(8'h78);
        add_subhdr(q, 1'b1, 32'd1);
        q.push_back(8'hFF);
        add_subhdr(q, 1'b0, 32'd2);
        q.push_back(8'h41);
        q.push_back(8'h42);
        send_file(q);
    endtask

    task automatic test_body_limits();
        t_byte_q q;
        // few body bytes left after a name, then trailing bytes
        add_header(q, 32'd14, 1'b1);
        add_subhdr(q, 1'b1, 32'd1);
        q.push_back(8'h5A);
        repeat (5 + 3) q.push_back(8'($urandom));
        send_file(q);
        // subrecord runs past the body end
        q.delete();
        add_header(q, 32'd12, 1'b1);
        add_subhdr(q, 1'b1, 32'd10);
        repeat (4) q.push_back(8'h61);
        send_file(q);
        // body cut short
        q.delete();
        add_header(q, 32'd20, 1'b1);
        add_subhdr(q, 1'b1, 32'd3);
        q.push_back(8'h61);
        q.push_back(8'h62);
        q.push_back(8'h63);
        send_file(q);
    endtask

    task automatic test_size_extremes();
        t_byte_q q;
        add_header(q, 32'd0, 1'b1);
        repeat (4) q.push_back(8'($urandom));
        send_file(q);
        // a 32-bit sum would wrap to zero here
        q.delete();
        add_header(q, 32'd16, 1'b1);
        add_subhdr(q, 1'b1, 32'hFFFF_FFF8);
        repeat (8) q.push_back(8'h41);
        send_file(q);
        q.delete();
        add_header(q, 32'hFFFF_FFFF, 1'b1);
        add_subhdr(q, 1'b1, 32'hFFFF_FFFF);
        q.push_back(8'h00);
        q.push_back(8'hFF);
        send_file(q);
    endtask

    task automatic build_random_file(ref t_byte_q q);
        t_byte_q     body;
        t_byte_q     payload;
        int          cut;
        int          nsub;
        logic [31:0] size_field;
        logic [31:0] body_size;
        bit          mast;
        nsub = $urandom_range(0, 4);
        repeat (nsub) begin
            payload.delete();
            mast = ($urandom_range(0, 9) < 6);
            if (mast) begin
                repeat ($urandom_range(0, 8)) payload.push_back(8'($urandom_range(1, 255)));
                if ($urandom_range(0, 9) < 3) begin
                    payload.push_back(NUL_BYTE);
                    repeat ($urandom_range(0, 3)) payload.push_back(8'($urandom));
                end
            end else begin
                repeat ($urandom_range(0, 6)) payload.push_back(8'($urandom));
            end
            size_field = payload.size();
            case ($urandom_range(0, 19))
                0: size_field = $urandom;
                1: size_field = size_field + $urandom_range(1, 20);
                default: ;
            endcase
            add_subhdr(body, mast, size_field);
            body = {body, payload};
        end
        body_size = body.size();
        case ($urandom_range(0, 9))
            0, 1: begin
                cut = $urandom_range(1, 7);
                body_size += cut;
                repeat (cut) body.push_back(8'($urandom));
            end
            2: if (body_size > 0) body_size -= $urandom_range(1, body_size);
            default: ;
        endcase
        add_header(q, body_size, $urandom_range(0, 9) != 0);
        q = {q, body};
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, q.size());
            while (q.size() > cut) void'(q.pop_back());
        end else if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        end
    endtask

    task automatic test_random_files();
        t_byte_q q;
        while (file_beats < FILE_BEATS) begin
            q.delete();
            choose_idling();
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(0, 30)) q.push_back(8'($urandom));
            else build_random_file(q);
            send_file(q);
            file_beats += q.size() + 1;
        end
    endtask

    initial begin
        clear_parser_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_header();
        test_bad_tag();
        test_master_names();
        choose_idling();
        test_body_limits();
        choose_idling();
        test_size_extremes();
        test_random_files();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("tes3_master_list_parser_test OK");
        else $display("tes3_master_list_parser_test NOT OK");
        $finish;
    end

endmodule
